// ===== design/ps2_mouse_packet_cursor_tracker_assert.svh =====
// Assertion macros shared by the cursor tracker checks.
`ifndef PS2_MOUSE_PACKET_CURSOR_TRACKER_ASSERT_SVH
`define PS2_MOUSE_PACKET_CURSOR_TRACKER_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define PMT_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while in reset.
`define PMT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/pmt_pkg.sv =====
// Types and constants for the PS/2 mouse packet cursor tracker.
package pmt_pkg;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_LIMIT_X = 1'b0,
    REG_LIMIT_Y = 1'b1
  } reg_idx_e;

  // Per-byte status codes
  typedef enum logic [1:0] {
    ST_STORED  = 2'd0,
    ST_DISCARD = 2'd1,
    ST_APPLIED = 2'd2,
    ST_DROPPED = 2'd3
  } byte_status_e;

  // Position of the next byte within a packet
  typedef enum logic [1:0] {
    POS_HEADER = 2'd0,
    POS_XDATA  = 2'd1,
    POS_YDATA  = 2'd2
  } byte_pos_e;

  // Header bit masks
  localparam logic [7:0] SyncMask  = 8'h08;
  localparam logic [7:0] OvfMask   = 8'hC0;
  localparam logic [7:0] XSignMask = 8'h10;
  localparam logic [7:0] YSignMask = 8'h20;
  localparam logic [7:0] BtnMask   = 8'h07;

  // Reset values
  localparam logic [15:0] LimitXReset = 16'd1023;
  localparam logic [15:0] LimitYReset = 16'd767;
  localparam logic [8:0]  PosXReset   = 9'd400;
  localparam logic [8:0]  PosYReset   = 9'd300;

endpackage

// ===== design/ps2_mouse_packet_cursor_tracker.sv =====
// PS/2 mouse packet assembler with clamped cursor tracking.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-------------------------------------
//  in      | to block  | in_valid_i / in_ready_o   | rx_byte_i
//  out     | from block| out_valid_o / out_ready_i | cursor_x/y, button_bits, events_seen,
//          |           |                           | byte_status
//  cfg     | to block  | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// One byte per cycle when not stalled; its result is in the output register next cycle.
// The packet state and cursor update in the same cycle the byte is taken.
// in_ready_o drops only while a result is held and out_ready_i is low.
// Reset restores the limits to 1023/767 and the cursor to 400/300.
module ps2_mouse_packet_cursor_tracker #(
  parameter int COORD_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] cursor_x_o,
  output logic [15:0] cursor_y_o,
  output logic [2:0]  button_bits_o,
  output logic [31:0] events_seen_o,
  output logic [1:0]  byte_status_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  // Working width for signed sums and clamp compares
  localparam int SW = ((COORD_BITS > 16) ? COORD_BITS : 16) + 2;
  localparam logic [SW-1:0] CoordMax = SW'({COORD_BITS{1'b1}});

  logic [15:0]             limit_x_q, limit_y_q;
  pmt_pkg::byte_pos_e      pos_q, pos_d;
  logic [7:0]              header_q, header_d;
  logic [7:0]              xdata_q, xdata_d;
  logic [COORD_BITS-1:0]   pos_x_q, pos_x_d;
  logic [COORD_BITS-1:0]   pos_y_q, pos_y_d;
  logic [2:0]              buttons_q, buttons_d;
  logic [31:0]             count_q, count_d;
  pmt_pkg::byte_status_e   status_d;
  logic                    out_valid_q;
  logic [15:0]             cursor_x_q, cursor_y_q;
  logic [2:0]              button_bits_q;
  logic [31:0]             events_seen_q;
  pmt_pkg::byte_status_e   byte_status_q;

  logic                    in_xfer;
  logic signed [8:0]       dx, dy;
  logic signed [SW-1:0]    sum_x, sum_y;
  logic [SW-1:0]           top_x, top_y;
  logic [SW-1:0]           clamp_x, clamp_y;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_xfer     = in_valid_i && in_ready_o;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_x_q <= pmt_pkg::LimitXReset;
      limit_y_q <= pmt_pkg::LimitYReset;
    end else if (cfg_valid_i) begin
      unique case (pmt_pkg::reg_idx_e'(cfg_index_i))
        pmt_pkg::REG_LIMIT_X: limit_x_q <= cfg_data_i;
        pmt_pkg::REG_LIMIT_Y: limit_y_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Deltas: 9-bit signed from header sign bit and data byte
  assign dx = {|(header_q & pmt_pkg::XSignMask), xdata_q};
  assign dy = {|(header_q & pmt_pkg::YSignMask), rx_byte_i};

  // X adds, Y subtracts
  assign sum_x = $signed(SW'(pos_x_q)) + {{(SW-9){dx[8]}}, dx};
  assign sum_y = $signed(SW'(pos_y_q)) - {{(SW-9){dy[8]}}, dy};

  // Clamp bound is the smaller of the limit and the coordinate range
  assign top_x = (SW'(limit_x_q) < CoordMax) ? SW'(limit_x_q) : CoordMax;
  assign top_y = (SW'(limit_y_q) < CoordMax) ? SW'(limit_y_q) : CoordMax;

  always_comb begin
    if (sum_x[SW-1])                clamp_x = '0;
    else if ($unsigned(sum_x) > top_x) clamp_x = top_x;
    else                            clamp_x = $unsigned(sum_x);
    if (sum_y[SW-1])                clamp_y = '0;
    else if ($unsigned(sum_y) > top_y) clamp_y = top_y;
    else                            clamp_y = $unsigned(sum_y);
  end

  // Packet sequencer
  always_comb begin
    pos_d     = pos_q;
    header_d  = header_q;
    xdata_d   = xdata_q;
    pos_x_d   = pos_x_q;
    pos_y_d   = pos_y_q;
    buttons_d = buttons_q;
    count_d   = count_q;
    status_d  = pmt_pkg::ST_STORED;
    unique case (pos_q)
      pmt_pkg::POS_HEADER: begin
        if ((rx_byte_i & pmt_pkg::SyncMask) == 8'h00) begin
          status_d = pmt_pkg::ST_DISCARD;
        end else begin
          header_d = rx_byte_i;
          pos_d    = pmt_pkg::POS_XDATA;
        end
      end
      pmt_pkg::POS_XDATA: begin
        xdata_d = rx_byte_i;
        pos_d   = pmt_pkg::POS_YDATA;
      end
      default: begin
        pos_d = pmt_pkg::POS_HEADER;
        if ((header_q & pmt_pkg::OvfMask) != 8'h00) begin
          status_d = pmt_pkg::ST_DROPPED;
        end else begin
          buttons_d = header_q[2:0] & pmt_pkg::BtnMask[2:0];
          pos_x_d   = clamp_x[COORD_BITS-1:0];
          pos_y_d   = clamp_y[COORD_BITS-1:0];
          count_d   = count_q + 32'd1;
          status_d  = pmt_pkg::ST_APPLIED;
        end
      end
    endcase
  end

  // Tracker state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= pmt_pkg::POS_HEADER;
      header_q  <= '0;
      xdata_q   <= '0;
      pos_x_q   <= COORD_BITS'(pmt_pkg::PosXReset);
      pos_y_q   <= COORD_BITS'(pmt_pkg::PosYReset);
      buttons_q <= '0;
      count_q   <= '0;
    end else if (in_xfer) begin
      pos_q     <= pos_d;
      header_q  <= header_d;
      xdata_q   <= xdata_d;
      pos_x_q   <= pos_x_d;
      pos_y_q   <= pos_y_d;
      buttons_q <= buttons_d;
      count_q   <= count_d;
    end
  end

  // Output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cursor_x_q    <= 16'(pos_x_d);
      cursor_y_q    <= 16'(pos_y_d);
      button_bits_q <= buttons_d;
      events_seen_q <= count_d;
      byte_status_q <= status_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign cursor_x_o    = cursor_x_q;
  assign cursor_y_o    = cursor_y_q;
  assign button_bits_o = button_bits_q;
  assign events_seen_o = events_seen_q;
  assign byte_status_o = byte_status_q;

endmodule

// ===== design/pmt_checker.sv =====
// Port-level checks for the cursor tracker, bound to the top level.
`include "ps2_mouse_packet_cursor_tracker_assert.svh"

module pmt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [7:0]  rx_byte_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] cursor_x_o,
  input logic [15:0] cursor_y_o,
  input logic [2:0]  button_bits_o,
  input logic [31:0] events_seen_o,
  input logic [1:0]  byte_status_o,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o
);

  // A held result keeps its payload
  `PMT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(cursor_x_o) && $stable(cursor_y_o) && $stable(button_bits_o) && $stable(events_seen_o) && $stable(byte_status_o), "output changed while stalled")

  // Every byte transfer yields a result in the next cycle
  `PMT_ASSERT_NEXT(a_in_to_out, clk_i, rst_ni, in_valid_i && in_ready_o, out_valid_o, "no result after byte transfer")

  // Input only stalls behind a held result
  `PMT_ASSERT_NOW(a_ready, clk_i, rst_ni, !out_valid_o || out_ready_i, in_ready_o, "input stalled without backpressure")

  // A waiting byte stays offered and unchanged
  `PMT_ASSERT_NEXT(a_in_hold, clk_i, rst_ni, in_valid_i && !in_ready_o, in_valid_i && $stable(rx_byte_i), "input byte changed while waiting")

  // Limit writes are never stalled
  `PMT_ASSERT_NOW(a_cfg_ready, clk_i, rst_ni, cfg_valid_i, cfg_ready_o, "configuration write stalled")

endmodule

bind ps2_mouse_packet_cursor_tracker pmt_checker u_pmt_checker (.*);

// ===== tb/tb_top.sv =====
// Self-checking testbench for the PS/2 mouse packet cursor tracker.
`timescale 1ns / 1ps

module tb_top;

  localparam int LongHold   = 150;
  localparam int QuietLimit = 4000;

  // Header sign handling for generated packets
  localparam int SignFree  = 0;
  localparam int SignClear = 1;
  localparam int SignSet   = 2;

  // What one byte should leave on the outputs
  typedef struct packed {
    logic [15:0]           x;
    logic [15:0]           y;
    logic [2:0]            btn;
    logic [31:0]           events;
    pmt_pkg::byte_status_e status;
  } cursor_view_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_ready = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [0:0]  cfg_index = pmt_pkg::REG_LIMIT_X;
  logic [15:0] cfg_data = 16'h0000;
  logic        in_ready_o;
  logic        out_valid_o;
  logic        cfg_ready_o;
  logic [15:0] cursor_x_o;
  logic [15:0] cursor_y_o;
  logic [2:0]  button_bits_o;
  logic [31:0] events_seen_o;
  logic [1:0]  byte_status_o;

  ps2_mouse_packet_cursor_tracker dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready_o),
    .rx_byte_i     (rx_byte),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready),
    .cursor_x_o    (cursor_x_o),
    .cursor_y_o    (cursor_y_o),
    .button_bits_o (button_bits_o),
    .events_seen_o (events_seen_o),
    .byte_status_o (byte_status_o),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Tracker copy: packet assembly, cursor and limits
  pmt_pkg::byte_pos_e pkt_phase  = pmt_pkg::POS_HEADER;
  logic [7:0]         hdr_seen   = 8'h00;
  logic [7:0]         xbyte_seen = 8'h00;
  logic [15:0]        cur_x      = 16'(pmt_pkg::PosXReset);
  logic [15:0]        cur_y      = 16'(pmt_pkg::PosYReset);
  logic [2:0]         btn_held   = 3'b000;
  logic [31:0]        pkt_total  = 32'd0;
  logic [15:0]        lim_x      = pmt_pkg::LimitXReset;
  logic [15:0]        lim_y      = pmt_pkg::LimitYReset;

  cursor_view_t pending_views[$];
  cursor_view_t head_view;

  int n_fail = 0;
  int n_bytes = 0;
  int n_applied = 0;
  int n_dropped = 0;
  int n_discarded = 0;
  int n_cfg = 0;

  // Sender pacing
  bit pace_on = 1'b0;
  int burst_left = 0;

  // Receiver stall control
  logic        stall_on = 1'b0;
  int          hold_reqs = 0;
  int          hold_grants = 0;
  int          hold_left = 0;
  logic [15:0] stall_pat = 16'hFFFF;
  int          pat_age = 0;

  int quiet_cycles = 0;

  function automatic logic [15:0] clamp_coord(input int v, input logic [15:0] lim);
    if (v < 0) return 16'd0;
    if (v > int'(lim)) return lim;
    return v[15:0];
  endfunction

  // Advance the tracker by one byte and return the outputs it should show
  function automatic cursor_view_t track_byte(input logic [7:0] b);
    cursor_view_t v;
    int dx;
    int dy;
    v.status = pmt_pkg::ST_STORED;
    case (pkt_phase)
      pmt_pkg::POS_HEADER: begin
        if ((b & pmt_pkg::SyncMask) == 8'h00) begin
          v.status = pmt_pkg::ST_DISCARD;
        end else begin
          hdr_seen = b;
          pkt_phase = pmt_pkg::POS_XDATA;
        end
      end
      pmt_pkg::POS_XDATA: begin
        xbyte_seen = b;
        pkt_phase = pmt_pkg::POS_YDATA;
      end
      default: begin
        pkt_phase = pmt_pkg::POS_HEADER;
        if ((hdr_seen & pmt_pkg::OvfMask) != 8'h00) begin
          v.status = pmt_pkg::ST_DROPPED;
        end else begin
          // 9-bit deltas: sign from the header, low eight bits from the data byte
          dx = ((hdr_seen & pmt_pkg::XSignMask) != 8'h00) ?
               int'(xbyte_seen) - 256 : int'(xbyte_seen);
          dy = ((hdr_seen & pmt_pkg::YSignMask) != 8'h00) ? int'(b) - 256 : int'(b);
          btn_held = hdr_seen[2:0] & pmt_pkg::BtnMask[2:0];
          cur_x = clamp_coord(int'(cur_x) + dx, lim_x);
          cur_y = clamp_coord(int'(cur_y) - dy, lim_y);
          pkt_total = pkt_total + 32'd1;
          v.status = pmt_pkg::ST_APPLIED;
        end
      end
    endcase
    v.x = cur_x;
    v.y = cur_y;
    v.btn = btn_held;
    v.events = pkt_total;
    return v;
  endfunction

  function automatic void check_field(input string fname, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", fname, want, got);
      n_fail++;
    end
  endfunction

  // Result checker: every output transfer against the oldest expectation
  always @(posedge clk) begin
    if (out_valid_o && out_ready) begin
      if (pending_views.size() == 0) begin
        $error("result transfer with no byte outstanding");
        n_fail++;
      end else begin
        head_view = pending_views.pop_front();
        check_field("cursor_x", 32'(head_view.x), 32'(cursor_x_o));
        check_field("cursor_y", 32'(head_view.y), 32'(cursor_y_o));
        check_field("button_bits", 32'(head_view.btn), 32'(button_bits_o));
        check_field("events_seen", head_view.events, events_seen_o);
        check_field("byte_status", 32'(head_view.status), 32'(byte_status_o));
      end
    end
  end

  // Receiver: long holds on request, otherwise ready or a rotating stall pattern
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_grants != hold_reqs) begin
      out_ready <= 1'b0;
      hold_grants <= hold_grants + 1;
      hold_left <= LongHold;
    end else if (!stall_on) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= stall_pat[0];
      if (pat_age == 63) begin
        pat_age <= 0;
        stall_pat <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
      end else begin
        pat_age <= pat_age + 1;
        stall_pat <= {stall_pat[0], stall_pat[15:1]};
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready_o) || (out_valid_o && out_ready) ||
        (cfg_valid && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("ps2_mouse_packet_cursor_tracker regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic pause(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Bursts of random length, mostly separated by random gaps
  task automatic pace();
    if (pace_on) begin
      if (burst_left == 0) begin
        pause(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15));
        burst_left = $urandom_range(1, 32);
      end
      burst_left--;
    end
  endtask

  // One byte transfer; the expectation is queued at the accepting edge
  task automatic send_byte(input logic [7:0] b);
    cursor_view_t v;
    pace();
    in_valid <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (!in_ready_o);
    v = track_byte(b);
    pending_views.push_back(v);
    n_bytes++;
    case (v.status)
      pmt_pkg::ST_APPLIED: n_applied++;
      pmt_pkg::ST_DROPPED: n_dropped++;
      pmt_pkg::ST_DISCARD: n_discarded++;
      default: ;
    endcase
  endtask

  // Stop sending and wait for every outstanding result
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic cfg_write(input pmt_pkg::reg_idx_e idx, input logic [15:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    if (idx == pmt_pkg::REG_LIMIT_X) lim_x = val;
    else lim_y = val;
    n_cfg++;
  endtask

  task automatic send_triplet(input logic [7:0] h, input logic [7:0] dx, input logic [7:0] dy);
    send_byte(h);
    send_byte(dx);
    send_byte(dy);
  endtask

  // Well-formed packet with random content; random overflow bits kept on about one in ten
  task automatic send_packet(input int x_mode, input int y_mode);
    logic [7:0] hdr;
    hdr = 8'($urandom) | pmt_pkg::SyncMask;
    if ($urandom_range(0, 9) != 0) hdr = hdr & ~pmt_pkg::OvfMask;
    if (x_mode == SignClear) hdr = hdr & ~pmt_pkg::XSignMask;
    else if (x_mode == SignSet) hdr = hdr | pmt_pkg::XSignMask;
    if (y_mode == SignClear) hdr = hdr & ~pmt_pkg::YSignMask;
    else if (y_mode == SignSet) hdr = hdr | pmt_pkg::YSignMask;
    send_triplet(hdr, 8'($urandom), 8'($urandom));
  endtask

  // Field extremes, unsynced headers, both overflow bits
  task automatic test_directed();
    send_byte(8'h00);
    send_byte(8'hF7);
    send_triplet(8'h08, 8'hFF, 8'h00);
    send_triplet(8'h3F, 8'h00, 8'h00);
    send_triplet(8'h18, 8'h01, 8'hFF);
    send_triplet(8'h0A, 8'h80, 8'h7F);
    send_triplet(8'h48, 8'h12, 8'h34);
    send_triplet(8'h88, 8'hFF, 8'hFF);
    send_triplet(8'hCF, 8'h00, 8'h00);
    drain();
  endtask

  // Limit extremes; a new limit only bites at the next applied packet
  task automatic test_limit_extremes();
    cfg_write(pmt_pkg::REG_LIMIT_X, 16'd0);
    cfg_write(pmt_pkg::REG_LIMIT_Y, 16'd0);
    send_byte(8'h08);
    send_byte(8'h00);
    cfg_write(pmt_pkg::REG_LIMIT_X, 16'd5);
    send_byte(8'h00);
    cfg_write(pmt_pkg::REG_LIMIT_X, 16'hFFFF);
    cfg_write(pmt_pkg::REG_LIMIT_Y, 16'hFFFF);
    send_triplet(8'h28, 8'hFF, 8'h01);
    send_triplet(8'h30, 8'h00, 8'hFF);
    cfg_write(pmt_pkg::REG_LIMIT_X, pmt_pkg::LimitXReset);
    cfg_write(pmt_pkg::REG_LIMIT_Y, pmt_pkg::LimitYReset);
  endtask

  task automatic run_phase(input logic [15:0] lx, input logic [15:0] ly, input int x_mode,
                           input int y_mode, input int noise_pct, input bit paced,
                           input bit stalled, input int n_items);
    int sent;
    cfg_write(pmt_pkg::REG_LIMIT_X, lx);
    cfg_write(pmt_pkg::REG_LIMIT_Y, ly);
    pace_on = paced;
    burst_left = 0;
    stall_on <= stalled;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        send_byte(8'($urandom));
        sent++;
      end else begin
        send_packet(x_mode, y_mode);
        sent += 3;
      end
    end
  endtask

  // Mostly well-formed packets under several limit settings, with noise bytes
  task automatic test_random_traffic();
    run_phase(pmt_pkg::LimitXReset, pmt_pkg::LimitYReset, SignFree, SignFree, 10, 1'b1,
              1'b1, 200);
    run_phase(16'd0, 16'd0, SignFree, SignFree, 10, 1'b1, 1'b1, 150);
    run_phase(16'hFFFF, 16'hFFFF, SignClear, SignSet, 5, 1'b1, 1'b0, 200);
    run_phase(16'($urandom_range(0, 600)), 16'($urandom_range(0, 600)),
              SignClear, SignSet, 8, 1'b1, 1'b1, 200);
    run_phase(16'($urandom), 16'($urandom), SignSet, SignClear, 8, 1'b0, 1'b1, 200);
    run_phase(16'($urandom), 16'($urandom), SignFree, SignFree, 30, 1'b0, 1'b0, 200);
    pace_on = 1'b0;
    stall_on <= 1'b0;
  endtask

  // Output held off while bytes keep coming, so the input stalls; then a full drain
  task automatic test_backpressure();
    int i;
    hold_reqs <= hold_reqs + 1;
    for (i = 0; i < 12; i++) send_packet(SignFree, SignFree);
    drain();
    stall_on <= 1'b1;
    pace_on = 1'b1;
    hold_reqs <= hold_reqs + 1;
    for (i = 0; i < 12; i++) send_packet(SignFree, SignFree);
    drain();
    pace_on = 1'b0;
    stall_on <= 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_limit_extremes();
    test_random_traffic();
    test_backpressure();
    drain();
    $display("Run covered %0d bytes: %0d packets applied, %0d overflow drops, %0d unsynced",
             n_bytes, n_applied, n_dropped, n_discarded);
    $display("%0d limit writes, bursty input, patterned and long output stalls", n_cfg);
    if (n_fail == 0) begin
      $display("ps2_mouse_packet_cursor_tracker regression: pass");
    end else begin
      $display("ps2_mouse_packet_cursor_tracker regression: fail");
    end
    $finish;
  end

endmodule
